>>> hw/rtl/bbt_pkg.sv
// Shared types and constants for the box bounds transform block.
// Holds lane formats, channel payloads and the product bundle between stages.
// No dependencies.
package bbt_pkg;

   localparam int LANE_W   = 16;
   localparam int LANES    = 3;
   localparam int PACK_W   = LANE_W * LANES;
   localparam int PROD_W   = 2 * LANE_W;
   localparam int FRAC_SH  = 14;

   typedef logic [LANE_W-1:0] lane_type;
   typedef logic [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic [PACK_W-1:0] box_center;
      logic [PACK_W-1:0] box_half;
      logic [PACK_W-1:0] matrix_row_x;
      logic [PACK_W-1:0] matrix_row_y;
      logic [PACK_W-1:0] matrix_row_z;
      logic [PACK_W-1:0] translation;
   } req_type;

   typedef struct packed {
      logic [PACK_W-1:0] world_center;
      logic [PACK_W-1:0] world_half;
      logic              saturated;
   } rsp_type;

   // products indexed [row][column]: row is the corner axis, column the world axis
   typedef struct packed {
      prod_type [LANES-1:0][LANES-1:0] cprod;
      prod_type [LANES-1:0][LANES-1:0] hprod;
      lane_type [LANES-1:0]            trans;
   } prod_set_type;

endpackage

>>> hw/rtl/bbt_req_if.sv
// Request channel of the box bounds transform: valid/ready plus box payload.
// Depends on bbt_pkg.
interface bbt_req_if;
   import bbt_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bbt_rsp_if.sv
// Response channel of the box bounds transform: valid/ready plus world bounds.
// Depends on bbt_pkg.
interface bbt_rsp_if;
   import bbt_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bbt_mul_stage.sv
// Multiply stage: center and half-extent lanes times each matrix coefficient.
// Registers the 18 products and the translation row. Depends on bbt_pkg.
module bbt_mul_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bbt_pkg::req_type      in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bbt_pkg::prod_set_type out_data
);
   import bbt_pkg::*;

   logic                        valid_ff;
   logic                        valid_in;
   prod_set_type                prod_ff;
   prod_set_type                prod_in;
   logic [LANES-1:0][PACK_W-1:0] rows;

   assign rows = {in_data.matrix_row_z, in_data.matrix_row_y, in_data.matrix_row_x};

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         for (int j = 0; j < LANES; j++) begin
            prod_in.cprod[i][j] = $signed(in_data.box_center[LANE_W*i +: LANE_W])
                                * $signed(rows[i][LANE_W*j +: LANE_W]);
            prod_in.hprod[i][j] = $signed(in_data.box_half[LANE_W*i +: LANE_W])
                                * $signed(rows[i][LANE_W*j +: LANE_W]);
         end
         prod_in.trans[i] = in_data.translation[LANE_W*i +: LANE_W];
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = prod_ff;

endmodule

>>> hw/rtl/bbt_sum_stage.sv
// Sum stage: adds products per world axis, rounds to Q8.8, clamps, flags.
// Center uses signed sums, half extents sum magnitudes. Depends on bbt_pkg.
module bbt_sum_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bbt_pkg::prod_set_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bbt_pkg::rsp_type      out_data
);
   import bbt_pkg::*;

   localparam int CSUM_W = PROD_W + 2;
   localparam int HSUM_W = PROD_W + 1;
   localparam int CQ_W   = CSUM_W - FRAC_SH;
   localparam int HQ_W   = HSUM_W - FRAC_SH;

   logic signed [CSUM_W-1:0] csum [LANES];
   logic signed [CSUM_W-1:0] crnd [LANES];
   logic        [HSUM_W-1:0] hsum [LANES];
   logic        [HSUM_W-1:0] hrnd [LANES];
   logic        [CQ_W-1:0]   cq   [LANES];
   logic        [HQ_W-1:0]   hq   [LANES];
   logic [LANES-1:0][LANES-1:0][PROD_W-1:0] habs;
   logic [LANES-1:0]         csat;
   logic [LANES-1:0]         hsat;

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         for (int j = 0; j < LANES; j++) begin
            habs[i][j] = in_data.hprod[i][j][PROD_W-1] ? (~in_data.hprod[i][j] + 1'b1)
                                                         : in_data.hprod[i][j];
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      for (int j = 0; j < LANES; j++) begin
         csum[j] = $signed({{(CSUM_W-LANE_W-FRAC_SH){in_data.trans[j][LANE_W-1]}},
                            in_data.trans[j], {FRAC_SH{1'b0}}})
                 + $signed({{2{in_data.cprod[0][j][PROD_W-1]}}, in_data.cprod[0][j]})
                 + $signed({{2{in_data.cprod[1][j][PROD_W-1]}}, in_data.cprod[1][j]})
                 + $signed({{2{in_data.cprod[2][j][PROD_W-1]}}, in_data.cprod[2][j]});
         crnd[j] = csum[j] + $signed(CSUM_W'(1) << (FRAC_SH - 1));
         cq[j]   = crnd[j][CSUM_W-1:FRAC_SH];
         csat[j] = (cq[j][CQ_W-1:LANE_W-1] != {(CQ_W-LANE_W+1){1'b0}})
                && (cq[j][CQ_W-1:LANE_W-1] != {(CQ_W-LANE_W+1){1'b1}});

         hsum[j] = {1'b0, habs[0][j]} + {1'b0, habs[1][j]} + {1'b0, habs[2][j]};
         hrnd[j] = hsum[j] + (HSUM_W'(1) << (FRAC_SH - 1));
         hq[j]   = hrnd[j][HSUM_W-1:FRAC_SH];
         hsat[j] = |hq[j][HQ_W-1:LANE_W-1];

         if (csat[j]) begin
            rsp_in.world_center[LANE_W*j +: LANE_W] =
               cq[j][CQ_W-1] ? {1'b1, {(LANE_W-1){1'b0}}} : {1'b0, {(LANE_W-1){1'b1}}};
         end else begin
            rsp_in.world_center[LANE_W*j +: LANE_W] = cq[j][LANE_W-1:0];
         end

         if (hsat[j]) begin
            rsp_in.world_half[LANE_W*j +: LANE_W] = {1'b0, {(LANE_W-1){1'b1}}};
         end else begin
            rsp_in.world_half[LANE_W*j +: LANE_W] = hq[j][LANE_W-1:0];
         end
      end
      rsp_in.saturated = (|csat) || (|hsat);
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

>>> hw/rtl/box_bounds_transform.sv
// World-space bounds of an affine-transformed axis-aligned box.
// Top level: multiply stage then sum stage. Depends on bbt_pkg, bbt_req_if,
// bbt_rsp_if, bbt_mul_stage and bbt_sum_stage.
//
// Usage:
//   req_chan carries one box per transfer: center and half extents (Q8.8
//   lanes), three matrix rows (Q2.14) and the translation row (Q8.8).
//   rsp_chan returns the world center, world half extents and a saturation
//   flag for every request, in order.
//   Response valid rises once the request has passed the two pipeline
//   registers (products, then rounded results). Throughput is one box per
//   cycle while the receiver is ready, since each of the two registers
//   advances whenever its successor is free.
//   Extents come from the center transform plus the absolute-value matrix
//   times the half extents, which gives the same min and max as the corners.
//   When the receiver stalls, the response holds and each stage keeps taking
//   data until it is full, so up to two boxes are held before req_chan.ready
//   drops. Reset empties both stages; their data registers are not reset.
module box_bounds_transform (
   input  logic      clock,
   input  logic      reset,
   bbt_req_if.sink   req_chan,
   bbt_rsp_if.source rsp_chan
);
   import bbt_pkg::*;

   logic         mid_valid;
   logic         mid_ready;
   prod_set_type mid_data;

   bbt_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_chan.data),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   bbt_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.data)
   );

endmodule
